### sv/rdc_pkg.sv
// shared type, constants and helper function of the radix digit converter
package rdc_pkg;

    localparam int VALUE_W = 31;
    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    // control of the digit row for one cycle
    typedef struct packed {
        logic clear;
        logic shift;
        logic bit_in;
    } rdc_row_ctl_t;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r > RADIX_MAX)
        begin
            res = RADIX_MAX;
        end
        else if (r < RADIX_MIN)
        begin
            res = RADIX_MIN;
        end
        return res;
    endfunction

endpackage

### sv/rdc_in_if.sv
// input channel: value and radix
interface rdc_in_if;
    import rdc_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

### sv/rdc_out_if.sv
// output channel: one digit per beat with last mark
interface rdc_out_if;
    import rdc_pkg::*;

    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit;
    logic               last;

    modport source (output valid, output digit, output last, input ready);
    modport sink   (input valid, input digit, input last, output ready);
endinterface

### sv/radix_digit_converter.sv
// Radix digit converter. Each input beat carries a value and a radix (2..16, lower radices
// are raised to 2 and higher ones cut to 16); the block returns the value's digits most
// significant first, one output beat per digit, the least significant marked last, and a
// zero value gives a single 0. The value is shifted in one bit per cycle, most significant
// first, into a row of VALUE_BITS digit cells that double and add the incoming bit; once
// every bit is in, the digits are read out of the row into the output register, waiting
// whenever the output is stalled. One value is converted at a time; the next is taken once
// the last digit of the previous one has been loaded into the output register.
module radix_digit_converter #(
    parameter int VALUE_BITS = 31
) (
    input  logic      clk,
    input  logic      rst_n,
    rdc_in_if.sink    in_chan,
    rdc_out_if.source out_chan
);
    import rdc_pkg::*;

    localparam int CW   = $clog2(VALUE_BITS + 1);
    localparam int IW   = $clog2(VALUE_BITS);
    localparam int WIDE = VALUE_BITS + VALUE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_EMIT
    } state_t;

    state_t                state_reg,   state_next;
    logic [VALUE_BITS-1:0] shreg_reg,   shreg_next;
    logic [CW-1:0]         bit_cnt_reg, bit_cnt_next;
    logic [CW-1:0]         count_reg,   count_next;
    logic [RADIX_W-1:0]    radix_reg,   radix_next;
    logic [IW-1:0]         idx_reg,     idx_next;
    logic                  ovalid_reg,  ovalid_next;
    logic [DIGIT_W-1:0]    digit_reg,   digit_next;
    logic                  last_reg,    last_next;

    rdc_row_ctl_t       row_ctl;
    logic               grow;
    logic [DIGIT_W-1:0] rd_digit;
    logic [WIDE-1:0]    value_wide;
    logic [CW-1:0]      count_grown;
    logic [CW-1:0]      top_idx;

    rdc_digit_row #(
        .CELLS (VALUE_BITS)
    ) u_row (
        .clk      (clk),
        .ctl      (row_ctl),
        .radix    (radix_reg),
        .count    (count_reg),
        .rd_idx   (idx_reg),
        .grow     (grow),
        .rd_digit (rd_digit)
    );

    assign in_chan.ready  = (state_reg == S_IDLE);
    assign out_chan.valid = ovalid_reg;
    assign out_chan.digit = digit_reg;
    assign out_chan.last  = last_reg;

    assign value_wide  = WIDE'(in_chan.value);
    assign count_grown = count_reg + CW'(grow);
    // index of the most significant digit, zero for a zero value
    assign top_idx     = (count_grown == '0) ? '0 : count_grown - CW'(1);

    always_comb
    begin
        state_next   = state_reg;
        shreg_next   = shreg_reg;
        bit_cnt_next = bit_cnt_reg;
        count_next   = count_reg;
        radix_next   = radix_reg;
        idx_next     = idx_reg;
        ovalid_next  = ovalid_reg;
        digit_next   = digit_reg;
        last_next    = last_reg;
        row_ctl      = '{clear: 1'b0, shift: 1'b0, bit_in: shreg_reg[VALUE_BITS-1]};

        if (out_chan.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_chan.valid)
                begin
                    shreg_next    = value_wide[VALUE_BITS-1:0];
                    radix_next    = clamp_radix(in_chan.radix);
                    bit_cnt_next  = '0;
                    count_next    = '0;
                    row_ctl.clear = 1'b1;
                    state_next    = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                row_ctl.shift = 1'b1;
                shreg_next    = shreg_reg << 1;
                count_next    = count_grown;
                bit_cnt_next  = bit_cnt_reg + CW'(1);
                if (bit_cnt_reg == CW'(VALUE_BITS - 1))
                begin
                    idx_next   = top_idx[IW-1:0];
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!ovalid_reg || out_chan.ready)
                begin
                    ovalid_next = 1'b1;
                    digit_next  = rd_digit;
                    last_next   = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - IW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shreg_reg   <= shreg_next;
        bit_cnt_reg <= bit_cnt_next;
        radix_reg   <= radix_next;
        idx_reg     <= idx_next;
        digit_reg   <= digit_next;
        last_reg    <= last_next;
    end

endmodule

### sv/rdc_digit_row.sv
// row of radix digit cells, doubled plus one input bit per cycle while shift is set
module rdc_digit_row #(
    parameter int CELLS = 31
) (
    input  logic                          clk,
    input  rdc_pkg::rdc_row_ctl_t         ctl,
    input  logic [rdc_pkg::RADIX_W-1:0]   radix,
    input  logic [$clog2(CELLS+1)-1:0]    count,
    input  logic [$clog2(CELLS)-1:0]      rd_idx,
    output logic                          grow,
    output logic [rdc_pkg::DIGIT_W-1:0]   rd_digit
);
    import rdc_pkg::*;

    logic [DIGIT_W-1:0] cells_reg  [CELLS];
    logic [DIGIT_W-1:0] cells_next [CELLS];

    logic [CELLS-1:0] gen;
    logic [CELLS-1:0] prop;
    logic [CELLS:0]   sum;
    logic [CELLS:0]   carry;

    // a cell overflows on doubling alone, or on doubling plus an incoming carry
    always_comb
    begin
        for (int i = 0; i < CELLS; i++)
        begin
            gen[i]  = ({1'b0, cells_reg[i], 1'b0} >= {1'b0, radix});
            prop[i] = ({1'b0, cells_reg[i], 1'b1} == {1'b0, radix});
        end
    end

    // carry chain resolved through one adder: a = g|p, b = g
    assign sum   = {1'b0, gen | prop} + {1'b0, gen} + {{CELLS{1'b0}}, ctl.bit_in};
    assign carry = sum ^ {1'b0, gen | prop} ^ {1'b0, gen};

    always_comb
    begin
        logic [DIGIT_W:0] t;
        t = '0;
        for (int i = 0; i < CELLS; i++)
        begin
            t = {cells_reg[i], carry[i]};
            if (carry[i+1])
            begin
                t = t - radix;
            end
            if (ctl.clear)
            begin
                cells_next[i] = '0;
            end
            else if (ctl.shift)
            begin
                cells_next[i] = t[DIGIT_W-1:0];
            end
            else
            begin
                cells_next[i] = cells_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CELLS; i++)
        begin
            cells_reg[i] <= cells_next[i];
        end
    end

    // a carry into the lowest unused cell adds one digit
    assign grow     = carry[count];
    assign rd_digit = cells_reg[rd_idx];

endmodule
